### hw/rtl/dpk_pkg.sv
package dpk_pkg;

  // one input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       unit_start;
    logic       packet_end;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       packet_done;
    logic [2:0] status;
  } out_item_t;

  // command codes from front to back
  localparam logic [1:0] CMD_BYTE = 2'd0;  // one data byte
  localparam logic [1:0] CMD_HDR  = 2'd1;  // start code plus two header bytes
  localparam logic [1:0] CMD_BARE = 2'd2;  // bare status beat

  // one command: all results of one input byte
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       done;
    logic [2:0] status;
  } cmd_t;

  // beat positions inside a header command
  localparam logic [2:0] HDR_ONE_IDX   = 3'd3;
  localparam logic [2:0] HDR_FIRST_IDX = 3'd4;
  localparam logic [2:0] HDR_LAST_IDX  = 3'd5;

  // unit kinds
  localparam logic [1:0] KIND_COPY = 2'd0;
  localparam logic [1:0] KIND_DROP = 2'd1;
  localparam logic [1:0] KIND_FRAG = 2'd2;

  // nal unit types
  localparam logic [5:0] TYPE_AP   = 6'd48;
  localparam logic [5:0] TYPE_FU   = 6'd49;
  localparam logic [5:0] TYPE_PACI = 6'd50;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TYPE      = 3'd1;
  localparam logic [2:0] ST_LAYER     = 3'd2;
  localparam logic [2:0] ST_TID       = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;
  localparam logic [2:0] ST_PACI      = 3'd5;

  // unit length needs
  localparam logic [2:0] NEED_HDR      = 3'd2;
  localparam logic [2:0] NEED_FU       = 3'd3;
  localparam logic [2:0] NEED_FU_DONL  = 3'd5;
  localparam logic [2:0] POS_FU_HDR    = 3'd2;
  localparam logic [2:0] POS_MAX       = 3'd7;

endpackage

### hw/rtl/dpk_front.sv
module dpk_front
  import dpk_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_data,
  input  logic     accept,
  input  in_item_t item,
  output logic     cmd_push,
  output cmd_t     cmd
);

  logic       donl_r;
  logic [2:0] pos_r, pos_nxt;
  logic [7:0] h1_r, h1_nxt;
  logic [7:0] h2_r, h2_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [2:0] err_r, err_nxt;
  logic       inp_r, inp_nxt;

  // short unit check at unit end
  function automatic logic [2:0] len_check(input logic [2:0] err, input logic [2:0] pos,
                                           input logic [1:0] kind, input logic donl);
    logic [2:0] need;
    need = NEED_HDR;
    if (pos >= NEED_HDR && kind == KIND_FRAG) need = donl ? NEED_FU_DONL : NEED_FU;
    if (err == ST_OK && pos < need) return ST_SHORT;
    return err;
  endfunction

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) donl_r <= 1'b0;
    else if (cfg_we) donl_r <= cfg_data;
  end

  // classify one byte
  always_comb begin
    logic [5:0] ntype;
    logic [5:0] lid;
    logic       emit;
    pos_nxt  = pos_r;
    h1_nxt   = h1_r;
    h2_nxt   = h2_r;
    kind_nxt = kind_r;
    err_nxt  = err_r;
    inp_nxt  = inp_r;
    emit     = 1'b0;
    cmd      = '0;
    ntype    = h1_r[6:1];
    lid      = {h1_r[0], item.in_byte[7:3]};

    // unit boundary
    if (!inp_r || item.unit_start) begin
      if (inp_r) err_nxt = len_check(err_nxt, pos_nxt, kind_nxt, donl_r);
      inp_nxt  = 1'b1;
      pos_nxt  = '0;
      kind_nxt = KIND_COPY;
    end

    // payload handling
    if (err_nxt == ST_OK) begin
      if (pos_nxt == 3'd0) begin
        h1_nxt = item.in_byte;
      end else if (pos_nxt == 3'd1) begin
        h2_nxt = item.in_byte;
        priority if (ntype > TYPE_PACI) err_nxt = ST_TYPE;
        else if (lid != 6'd0) err_nxt = ST_LAYER;
        else if (item.in_byte[2:0] == 3'd0) err_nxt = ST_TID;
        else if (ntype == TYPE_PACI) err_nxt = ST_PACI;
        else if (ntype == TYPE_AP) kind_nxt = KIND_DROP;
        else if (ntype == TYPE_FU) kind_nxt = KIND_FRAG;
        else begin
          kind_nxt  = KIND_COPY;
          emit      = 1'b1;
          cmd.mode  = CMD_HDR;
          cmd.byte0 = h1_r;
          cmd.byte1 = item.in_byte;
        end
      end else if (kind_nxt == KIND_COPY) begin
        emit      = 1'b1;
        cmd.mode  = CMD_BYTE;
        cmd.byte0 = item.in_byte;
      end else if (kind_nxt == KIND_FRAG) begin
        if (pos_nxt == POS_FU_HDR) begin
          if (item.in_byte[7]) begin
            emit      = 1'b1;
            cmd.mode  = CMD_HDR;
            cmd.byte0 = {h1_r[7], item.in_byte[5:0], h1_r[0]};
            cmd.byte1 = h2_r;
          end
        end else if (!(donl_r && pos_nxt < NEED_FU_DONL)) begin
          emit      = 1'b1;
          cmd.mode  = CMD_BYTE;
          cmd.byte0 = item.in_byte;
        end
      end
    end

    if (pos_nxt < POS_MAX) pos_nxt = pos_nxt + 3'd1;

    // packet end closes the packet
    if (item.packet_end) begin
      err_nxt = len_check(err_nxt, pos_nxt, kind_nxt, donl_r);
      if (!emit) begin
        emit      = 1'b1;
        cmd.mode  = CMD_BARE;
        cmd.byte0 = '0;
      end
      cmd.done   = 1'b1;
      cmd.status = err_nxt;
      inp_nxt    = 1'b0;
      err_nxt    = ST_OK;
      pos_nxt    = '0;
      kind_nxt   = KIND_COPY;
    end

    cmd_push = accept && emit;
  end

  // unit and packet state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      h1_r   <= '0;
      h2_r   <= '0;
      kind_r <= KIND_COPY;
      err_r  <= ST_OK;
      inp_r  <= 1'b0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      h1_r   <= h1_nxt;
      h2_r   <= h2_nxt;
      kind_r <= kind_nxt;
      err_r  <= err_nxt;
      inp_r  <= inp_nxt;
    end
  end

endmodule

### hw/rtl/dpk_cmdq.sv
module dpk_cmdq
  import dpk_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic q_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = slot_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
    end
    if (rd_en) begin
      rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
    end
    if (wr_en && !rd_en) cnt_nxt = cnt_r + CW'(1);
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wp_r] <= wr_data;
  end

endmodule

### hw/rtl/dpk_back.sv
module dpk_back
  import dpk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_data,
  output logic      q_pop,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);

  cmd_t       cur_r;
  logic       cur_vld_r, cur_vld_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       last;
  logic       load;

  // result beat from the current command
  always_comb begin
    out_item            = '0;
    last                = 1'b1;
    unique case (cur_r.mode)
      CMD_HDR: begin
        last                = (idx_r == HDR_LAST_IDX);
        out_item.byte_valid = 1'b1;
        if (idx_r == HDR_ONE_IDX) out_item.out_byte = 8'd1;
        else if (idx_r == HDR_FIRST_IDX) out_item.out_byte = cur_r.byte0;
        else if (idx_r == HDR_LAST_IDX) out_item.out_byte = cur_r.byte1;
      end
      CMD_BYTE: begin
        out_item.byte_valid = 1'b1;
        out_item.out_byte   = cur_r.byte0;
      end
      CMD_BARE: out_item.byte_valid = 1'b0;
      default:  out_item.byte_valid = 1'b0;
    endcase
    out_item.run_last    = last;
    out_item.packet_done = last && cur_r.done;
    out_item.status      = last ? cur_r.status : ST_OK;
  end

  assign empty = !cur_vld_r;
  assign load  = !cur_vld_r || (pop && last);
  assign q_pop = load && !q_empty;

  // beat sequencing
  always_comb begin
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (load) begin
      cur_vld_nxt = !q_empty;
      idx_nxt     = '0;
    end else if (pop) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

endmodule

### hw/rtl/h265_rtp_depacketizer.sv
// channel   dir  handshake         payload
// input     in   push / full       in_item   (in_byte, unit_start, packet_end)
// result    out  empty / pop       out_item  (out_byte, byte_valid, run_last,
//                                             packet_done, status)
// config    in   cfg_we            cfg_data  (donl_present)
//
// an input byte is classified in the cycle it is taken; full only rises when the
// command queue of QUEUE_DEPTH entries is full
// the back end drains one result beat per cycle while pop is high: a data byte or
// bare status gives one beat, a start code with header gives six beats
// sustained rate is one byte per cycle on payload while full is low; header bursts
// are absorbed by the command queue, which feeds the back end's command register
// reset is synchronous and active low, clears queue, unit state and config
module h265_rtp_depacketizer
  import dpk_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_data,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic cmd_push;
  cmd_t cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_data;

  assign full = q_full;

  // classify and track units
  dpk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (push && !q_full),
    .item     (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  // command queue between front and back
  dpk_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_empty (q_empty)
  );

  // expand commands into result beats
  dpk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

  // a packet's final beat always closes the run of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.packet_done) |-> out_item.run_last)
    else $error("packet_done without run_last");

  // error status only on the packet's final beat
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != ST_OK) |-> out_item.packet_done)
    else $error("status on a beat that is not packet_done");

  // a bare status beat only closes a packet
  a_bare_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.byte_valid) |-> out_item.packet_done)
    else $error("bare beat without packet_done");

  // a beat not taken stays on the ports
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result beat changed while stalled");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import dpk_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT  = 10;

  // phases after the directed packets: donl setting and item count
  localparam logic PHASE_DONL [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
  localparam int   PHASE_ITEMS[4] = '{100, 100, 100, 90};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_data = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  h265_rtp_depacketizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // clock
  always #4 clk = ~clk;

  // beats waiting to be sent and stream beats waiting to arrive
  in_item_t  pending_items[$];
  out_item_t expected_beats[$];
  out_item_t beat_res[$];

  // predictor state
  logic       donl_on = 1'b0;
  logic [2:0] unit_pos = '0;
  logic [7:0] hdr_first = '0;
  logic [7:0] hdr_second = '0;
  logic [1:0] unit_kind_q = KIND_COPY;
  logic [2:0] pkt_status = ST_OK;
  logic       in_pkt = 1'b0;

  logic       steady = 1'b0;
  int         fail_count = 0;
  int         items_queued = 0;
  int         beats_in = 0;
  int         beats_out = 0;
  int         packets_in = 0;
  out_item_t  got_beat;
  out_item_t  want_beat;

  function automatic string show(input out_item_t o);
    return $sformatf("byte=%02h valid=%0b last=%0b done=%0b status=%0d",
                     o.out_byte, o.byte_valid, o.run_last, o.packet_done, o.status);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("mismatch @%0t: %s", $realtime, msg);
    end
  endtask

  // one stream byte
  task automatic put_data(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    r.byte_valid = 1'b1;
    beat_res.insert(beat_res.size(), r);
  endtask

  // annex-b start code
  task automatic put_start();
    put_data(8'h00);
    put_data(8'h00);
    put_data(8'h00);
    put_data(8'h01);
  endtask

  // unit ends: flag it if too short for its headers
  task automatic close_unit();
    logic [2:0] need;
    need = NEED_HDR;
    if (pkt_status == ST_OK) begin
      if (unit_pos >= NEED_HDR && unit_kind_q == KIND_FRAG) begin
        need = donl_on ? NEED_FU_DONL : NEED_FU;
      end
      if (unit_pos < need) pkt_status = ST_SHORT;
    end
  endtask

  // both header bytes held: classify the unit
  task automatic judge_header();
    logic [5:0] typ;
    logic [5:0] lid;
    logic [2:0] tid;
    typ = hdr_first[6:1];
    lid = {hdr_first[0], hdr_second[7:3]};
    tid = hdr_second[2:0];
    if (typ > TYPE_PACI) begin
      pkt_status = ST_TYPE;
    end else if (lid != '0) begin
      pkt_status = ST_LAYER;
    end else if (tid == '0) begin
      pkt_status = ST_TID;
    end else if (typ == TYPE_PACI) begin
      pkt_status = ST_PACI;
    end else if (typ == TYPE_AP) begin
      unit_kind_q = KIND_DROP;
    end else if (typ == TYPE_FU) begin
      unit_kind_q = KIND_FRAG;
    end else begin
      unit_kind_q = KIND_COPY;
      put_start();
      put_data(hdr_first);
      put_data(hdr_second);
    end
  endtask

  // stream beats caused by one accepted input beat
  task automatic depacketize_beat(input in_item_t it);
    out_item_t bare;
    int last;
    beat_res.delete();
    if (!in_pkt || it.unit_start) begin
      if (in_pkt) close_unit();
      in_pkt = 1'b1;
      unit_pos = '0;
      unit_kind_q = KIND_COPY;
    end
    if (pkt_status == ST_OK) begin
      if (unit_pos == 3'd0) begin
        hdr_first = it.in_byte;
      end else if (unit_pos == 3'd1) begin
        hdr_second = it.in_byte;
        judge_header();
      end else if (unit_kind_q == KIND_COPY) begin
        put_data(it.in_byte);
      end else if (unit_kind_q == KIND_FRAG) begin
        if (unit_pos == POS_FU_HDR) begin
          if (it.in_byte[7]) begin
            put_start();
            put_data((hdr_first & 8'h81) | {1'b0, it.in_byte[5:0], 1'b0});
            put_data(hdr_second);
          end
        end else if (!(donl_on && unit_pos < NEED_FU_DONL)) begin
          put_data(it.in_byte);
        end
      end
    end
    if (unit_pos < POS_MAX) unit_pos++;
    if (it.packet_end) begin
      close_unit();
      if (beat_res.size() == 0) begin
        bare = '0;
        beat_res.insert(beat_res.size(), bare);
      end
      last = beat_res.size() - 1;
      beat_res[last].packet_done = 1'b1;
      beat_res[last].status = pkt_status;
      in_pkt = 1'b0;
      pkt_status = ST_OK;
      unit_pos = '0;
      unit_kind_q = KIND_COPY;
    end
    if (beat_res.size() > 0) begin
      last = beat_res.size() - 1;
      beat_res[last].run_last = 1'b1;
    end
    foreach (beat_res[i]) expected_beats.insert(expected_beats.size(), beat_res[i]);
  endtask

  task automatic push_item(input logic [7:0] b, input logic us, input logic pe);
    in_item_t it;
    it.in_byte = b;
    it.unit_start = us;
    it.packet_end = pe;
    pending_items.insert(pending_items.size(), it);
    items_queued++;
  endtask

  // one random packet: mostly well-formed units, some broken or noise
  task automatic add_packet();
    logic [7:0] bytes_q[$];
    logic       marks_q[$];
    logic [7:0] unit_q[$];
    int         n_units;
    int         sel;
    int         cut;
    logic [5:0] typ;
    logic [5:0] lid;
    logic [2:0] tid;
    logic       fbit;
    n_units = $urandom_range(1, 3);
    for (int u = 0; u < n_units; u++) begin
      unit_q.delete();
      sel = $urandom_range(0, 99);
      typ = 6'($urandom_range(0, 47));
      lid = '0;
      tid = 3'($urandom_range(1, 7));
      fbit = 1'($urandom_range(0, 1));
      if (sel >= 40) begin
        if (sel < 55) typ = TYPE_AP;
        else if (sel < 80) typ = TYPE_FU;
        else if (sel < 84) typ = TYPE_PACI;
        else if (sel < 88) typ = 6'($urandom_range(51, 63));
        else if (sel < 92) begin
          lid = 6'($urandom_range(1, 63));
          typ = 6'($urandom_range(0, 63));
        end else begin
          tid = '0;
          typ = 6'($urandom_range(0, 63));
        end
      end
      if (sel < 96) begin
        unit_q.insert(unit_q.size(), {fbit, typ, lid[5]});
        unit_q.insert(unit_q.size(), {lid[4:0], tid});
        if (typ == TYPE_FU) begin
          // fragment header, then decoding order number when enabled
          unit_q.insert(unit_q.size(), 8'($urandom_range(0, 255)));
          if (donl_on) begin
            unit_q.insert(unit_q.size(), 8'($urandom_range(0, 255)));
            unit_q.insert(unit_q.size(), 8'($urandom_range(0, 255)));
          end
        end
        repeat ($urandom_range(0, 5)) unit_q.insert(unit_q.size(), 8'($urandom_range(0, 255)));
        // truncated unit now and then
        if ($urandom_range(0, 9) == 0) begin
          cut = $urandom_range(1, unit_q.size());
          while (unit_q.size() > cut) void'(unit_q.pop_back());
        end
      end else begin
        repeat ($urandom_range(1, 6)) unit_q.insert(unit_q.size(), 8'($urandom_range(0, 255)));
      end
      foreach (unit_q[i]) begin
        bytes_q.insert(bytes_q.size(), unit_q[i]);
        if (i == 0) marks_q.insert(marks_q.size(), u == 0 ? 1'($urandom_range(0, 1)) : 1'b1);
        else marks_q.insert(marks_q.size(), $urandom_range(0, 49) == 0);
      end
    end
    foreach (bytes_q[i]) push_item(bytes_q[i], marks_q[i], i == bytes_q.size() - 1);
  endtask

  // wait for all beats sent and all stream beats back, then let the block go quiet
  task automatic settle();
    while (pending_items.size() != 0 || expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_donl(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    donl_on = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= 25)) begin
      push <= 1'b1;
      in_item <= pending_items[0];
    end else begin
      push <= 1'b0;
    end
  end

  // accepted input beat: predict its stream beats
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      depacketize_beat(in_item);
      void'(pending_items.pop_front());
      beats_in++;
      if (in_item.packet_end) packets_in++;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    pop <= rst_n && (steady || $urandom_range(0, 99) >= 25);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      got_beat = out_item;
      beats_out++;
      if (expected_beats.size() == 0) begin
        note_failure($sformatf("unexpected beat %s", show(got_beat)));
      end else begin
        want_beat = expected_beats.pop_front();
        if (got_beat.out_byte !== want_beat.out_byte ||
            got_beat.byte_valid !== want_beat.byte_valid ||
            got_beat.run_last !== want_beat.run_last ||
            got_beat.packet_done !== want_beat.packet_done ||
            got_beat.status !== want_beat.status) begin
          note_failure($sformatf("expected %s, got %s", show(want_beat), show(got_beat)));
        end
      end
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // sequence of phases
  initial begin
    int goal;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_donl(1'b0);

    // directed: plain unit with byte extremes
    push_item(8'h02, 1'b1, 1'b0);
    push_item(8'h01, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b1);
    // packet of one byte, too short
    push_item(8'hff, 1'b1, 1'b1);
    // fragmentation unit with start bit
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h01, 1'b0, 1'b0);
    push_item(8'h81, 1'b0, 1'b0);
    push_item(8'haa, 1'b0, 1'b1);
    // aggregation type dropped, first byte without unit mark
    push_item(8'h60, 1'b0, 1'b0);
    push_item(8'h01, 1'b0, 1'b0);
    push_item(8'h12, 1'b0, 1'b1);
    // paci unit
    push_item(8'h64, 1'b1, 1'b0);
    push_item(8'h01, 1'b0, 1'b1);
    // type above paci
    push_item(8'h7e, 1'b1, 1'b0);
    push_item(8'h01, 1'b0, 1'b1);
    // layer id set, later bytes silenced
    push_item(8'h03, 1'b1, 1'b0);
    push_item(8'h01, 1'b0, 1'b0);
    push_item(8'h33, 1'b0, 1'b1);
    // temporal id zero
    push_item(8'h02, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    // good unit then a one-byte unit at packet end
    push_item(8'h02, 1'b1, 1'b0);
    push_item(8'h01, 1'b0, 1'b0);
    push_item(8'h55, 1'b0, 1'b0);
    push_item(8'h02, 1'b1, 1'b1);
    settle();

    // random phases, one of them without stalls
    for (int p = 0; p < 4; p++) begin
      write_donl(PHASE_DONL[p]);
      steady = (p == 1);
      goal = items_queued + PHASE_ITEMS[p];
      while (items_queued < goal) add_packet();
      settle();
    end
    steady = 1'b0;

    foreach (expected_beats[i]) note_failure($sformatf("missing %s", show(expected_beats[i])));
    $display("sent %0d input beats in %0d packets, checked %0d stream beats",
             beats_in, packets_in, beats_out);
    $display("donl setting toggled across 5 phases, %0d failures", fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dpk_pkg.sv
hw/rtl/dpk_front.sv
hw/rtl/dpk_cmdq.sv
hw/rtl/dpk_back.sv
hw/rtl/h265_rtp_depacketizer.sv
tb/tb.sv
